>>> rtl/erst_pkg.sv
`timescale 1ns / 1ps
// Package for the echo reply slot table: sizes, codes, FSM states,
// and the request structs passed between modules. No dependencies.
package erst_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int QUEUE_DEPTH = 16;

  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int QADDR_W = SLOT_W + PTR_W;

  localparam int ACTION_W = 2;
  localparam int SID_W    = 16;
  localparam int ADDR_W   = 64;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 3;
  localparam int SLOTO_W  = 6;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REGISTER = 2'd0,
    ACT_DELIVER  = 2'd1,
    ACT_RECEIVE  = 2'd2,
    ACT_RELEASE  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_DUP        = 3'd1,
    ST_FULL_TABLE = 3'd2,
    ST_BAD_SLOT   = 3'd3,
    ST_UNUSED     = 3'd4,
    ST_EMPTY      = 3'd5,
    ST_FULL_QUEUE = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SCANEND,
    S_QRD,
    S_QOUT
  } state_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
  } scan_wr_t;

  typedef struct packed {
    logic                wr_en;
    logic [QADDR_W-1:0]  wr_addr;
    logic [HANDLE_W-1:0] wr_data;
    logic                rd_en;
    logic [QADDR_W-1:0]  rd_addr;
  } ram_req_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

>>> rtl/erst_handle_ram.sv
`timescale 1ns / 1ps
// Handle queue storage: one write port, one registered read port.
// Address is {slot, pointer}. Depends on erst_pkg.
module erst_handle_ram (
  input  logic                              clk,
  input  erst_pkg::ram_req_t                req,
  output logic [erst_pkg::HANDLE_W-1:0]     rd_data
);

  logic [erst_pkg::HANDLE_W-1:0] mem [1 << erst_pkg::QADDR_W];
  logic [erst_pkg::HANDLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/erst_addr_scan.sv
`timescale 1ns / 1ps
// Remote address register file with the shared 128-bit comparator
// stepped over slots by the sequencer. Depends on erst_pkg.
module erst_addr_scan (
  input  logic                             clk,
  input  erst_pkg::scan_wr_t               wr,
  input  logic [erst_pkg::SLOT_W-1:0]      rd_slot,
  input  logic [erst_pkg::ADDR_W-1:0]      key_hi,
  input  logic [erst_pkg::ADDR_W-1:0]      key_lo,
  output logic                             match
);

  logic [erst_pkg::ADDR_W-1:0] hi_r [erst_pkg::NUM_SLOTS];
  logic [erst_pkg::ADDR_W-1:0] lo_r [erst_pkg::NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      hi_r[wr.slot] <= wr.hi;
      lo_r[wr.slot] <= wr.lo;
    end
  end

  assign match = (hi_r[rd_slot] == key_hi) && (lo_r[rd_slot] == key_lo);

endmodule

>>> rtl/echo_reply_slot_table_core.sv
`timescale 1ns / 1ps
// Echo reply slot table top: sequencer, per-slot queue state, output register.
// Depends on erst_pkg, erst_addr_scan, erst_handle_ram.
//
// Input channel in_*: one transaction per action (register, deliver, receive,
// release). in_stall is high while an action is in progress; one action is
// worked on at a time.
// Output channel out_*: one result per action, except release, which emits
// one result per queued handle (oldest first) with out_last on the final one.
// Register steps the shared address comparator over the slots, one slot
// compared per cycle, and stops at the first duplicate. Receive and release
// read each handle through S_QRD and S_QOUT (queue RAM read is registered).
// Deliver, rejected deliver/receive/release and empty receive/release are
// answered from S_DISPATCH.
// The output register lets a new action be accepted while the last result
// still waits. When out_stall holds, the sequencer waits before emitting;
// the held result stays unchanged.
// Reset: all slots free, queue pointers and counts zero, output empty.
// Address and handle storage is not cleared.
module echo_reply_slot_table_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [erst_pkg::ACTION_W-1:0]     in_action,
  input  logic [erst_pkg::SID_W-1:0]        in_slot,
  input  logic [erst_pkg::ADDR_W-1:0]       in_remote_addr_hi,
  input  logic [erst_pkg::ADDR_W-1:0]       in_remote_addr_lo,
  input  logic [erst_pkg::HANDLE_W-1:0]     in_packet_handle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [erst_pkg::STATUS_W-1:0]     out_status,
  output logic [erst_pkg::SLOTO_W-1:0]      out_slot_out,
  output logic [erst_pkg::HANDLE_W-1:0]     out_packet_handle_out,
  output logic                              out_last
);

  erst_pkg::state_t                state_r, state_nxt;
  erst_pkg::action_t               action_r;
  logic [erst_pkg::SID_W-1:0]      sid_r;
  logic [erst_pkg::ADDR_W-1:0]     key_hi_r, key_lo_r;
  logic [erst_pkg::HANDLE_W-1:0]   handle_r;

  logic [erst_pkg::NUM_SLOTS-1:0]  in_use_r, in_use_nxt;
  logic [erst_pkg::PTR_W-1:0]      head_r [erst_pkg::NUM_SLOTS];
  logic [erst_pkg::PTR_W-1:0]      head_nxt [erst_pkg::NUM_SLOTS];
  logic [erst_pkg::PTR_W-1:0]      tail_r [erst_pkg::NUM_SLOTS];
  logic [erst_pkg::PTR_W-1:0]      tail_nxt [erst_pkg::NUM_SLOTS];
  logic [erst_pkg::CNT_W-1:0]      cnt_r [erst_pkg::NUM_SLOTS];
  logic [erst_pkg::CNT_W-1:0]      cnt_nxt [erst_pkg::NUM_SLOTS];

  logic [erst_pkg::SLOT_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                            free_found_r, free_found_nxt;
  logic [erst_pkg::SLOT_W-1:0]     free_slot_r, free_slot_nxt;

  logic                            out_valid_r, out_valid_nxt;
  erst_pkg::status_t               out_status_r, res_status;
  logic [erst_pkg::SLOTO_W-1:0]    out_slot_r, res_slot;
  logic [erst_pkg::HANDLE_W-1:0]   out_handle_r, res_handle;
  logic                            out_last_r, res_last;

  logic                            emit_c;
  logic                            out_free;
  logic                            sid_ok;
  logic [erst_pkg::SLOT_W-1:0]     sidx;
  logic [erst_pkg::CNT_W-1:0]      cur_cnt;
  logic                            scan_match;
  logic [erst_pkg::HANDLE_W-1:0]   ram_rd_data;
  erst_pkg::scan_wr_t              scan_wr;
  erst_pkg::ram_req_t              ram_req;

  erst_addr_scan u_addr_scan (
    .clk     (clk),
    .wr      (scan_wr),
    .rd_slot (scan_idx_r),
    .key_hi  (key_hi_r),
    .key_lo  (key_lo_r),
    .match   (scan_match)
  );

  erst_handle_ram u_handle_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  assign in_stall = (state_r != erst_pkg::S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign sid_ok   = (sid_r < erst_pkg::SID_W'(erst_pkg::NUM_SLOTS));
  assign sidx     = sid_r[erst_pkg::SLOT_W-1:0];
  assign cur_cnt  = cnt_r[sidx];

  always_comb begin
    state_nxt      = state_r;
    in_use_nxt     = in_use_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    scan_idx_nxt   = scan_idx_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    emit_c         = 1'b0;
    res_status     = erst_pkg::ST_OK;
    res_slot       = erst_pkg::SLOTO_W'(sidx);
    res_handle     = '0;
    res_last       = 1'b1;
    scan_wr.en     = 1'b0;
    scan_wr.slot   = free_slot_r;
    scan_wr.hi     = key_hi_r;
    scan_wr.lo     = key_lo_r;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = {sidx, tail_r[sidx]};
    ram_req.wr_data = handle_r;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = {sidx, head_r[sidx]};

    unique case (state_r)
      erst_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = erst_pkg::S_DISPATCH;
        end
      end
      erst_pkg::S_DISPATCH: begin
        if (action_r == erst_pkg::ACT_REGISTER) begin
          scan_idx_nxt   = '0;
          free_found_nxt = 1'b0;
          state_nxt      = erst_pkg::S_SCAN;
        end else if (!sid_ok) begin
          res_status = erst_pkg::ST_BAD_SLOT;
          res_slot   = '0;
          res_handle = (action_r == erst_pkg::ACT_DELIVER) ? handle_r : '0;
          if (out_free) begin
            emit_c    = 1'b1;
            state_nxt = erst_pkg::S_IDLE;
          end
        end else if (!in_use_r[sidx]) begin
          res_status = erst_pkg::ST_UNUSED;
          res_handle = (action_r == erst_pkg::ACT_DELIVER) ? handle_r : '0;
          if (out_free) begin
            emit_c    = 1'b1;
            state_nxt = erst_pkg::S_IDLE;
          end
        end else begin
          case (action_r)
            erst_pkg::ACT_DELIVER: begin
              if (cur_cnt == erst_pkg::CNT_W'(erst_pkg::QUEUE_DEPTH)) begin
                res_status = erst_pkg::ST_FULL_QUEUE;
                res_handle = handle_r;
                if (out_free) begin
                  emit_c    = 1'b1;
                  state_nxt = erst_pkg::S_IDLE;
                end
              end else if (out_free) begin
                emit_c         = 1'b1;
                state_nxt      = erst_pkg::S_IDLE;
                ram_req.wr_en  = 1'b1;
                tail_nxt[sidx] = erst_pkg::ptr_next(tail_r[sidx]);
                cnt_nxt[sidx]  = cur_cnt + erst_pkg::CNT_W'(1);
              end
            end
            erst_pkg::ACT_RECEIVE: begin
              if (cur_cnt == '0) begin
                res_status = erst_pkg::ST_EMPTY;
                if (out_free) begin
                  emit_c    = 1'b1;
                  state_nxt = erst_pkg::S_IDLE;
                end
              end else begin
                state_nxt = erst_pkg::S_QRD;
              end
            end
            default: begin
              if (cur_cnt != '0) begin
                state_nxt = erst_pkg::S_QRD;
              end else if (out_free) begin
                emit_c           = 1'b1;
                state_nxt        = erst_pkg::S_IDLE;
                in_use_nxt[sidx] = 1'b0;
                head_nxt[sidx]   = '0;
                tail_nxt[sidx]   = '0;
              end
            end
          endcase
        end
      end
      erst_pkg::S_SCAN: begin
        if (in_use_r[scan_idx_r] && scan_match) begin
          res_status = erst_pkg::ST_DUP;
          res_slot   = erst_pkg::SLOTO_W'(scan_idx_r);
          if (out_free) begin
            emit_c    = 1'b1;
            state_nxt = erst_pkg::S_IDLE;
          end
        end else begin
          if (!in_use_r[scan_idx_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_slot_nxt  = scan_idx_r;
          end
          if (scan_idx_r == erst_pkg::SLOT_W'(erst_pkg::NUM_SLOTS - 1)) begin
            state_nxt = erst_pkg::S_SCANEND;
          end else begin
            scan_idx_nxt = scan_idx_r + erst_pkg::SLOT_W'(1);
          end
        end
      end
      erst_pkg::S_SCANEND: begin
        if (free_found_r) begin
          res_slot = erst_pkg::SLOTO_W'(free_slot_r);
        end else begin
          res_status = erst_pkg::ST_FULL_TABLE;
          res_slot   = '0;
        end
        if (out_free) begin
          emit_c    = 1'b1;
          state_nxt = erst_pkg::S_IDLE;
          if (free_found_r) begin
            scan_wr.en                = 1'b1;
            in_use_nxt[free_slot_r]   = 1'b1;
            head_nxt[free_slot_r]     = '0;
            tail_nxt[free_slot_r]     = '0;
            cnt_nxt[free_slot_r]      = '0;
          end
        end
      end
      erst_pkg::S_QRD: begin
        ram_req.rd_en = 1'b1;
        state_nxt     = erst_pkg::S_QOUT;
      end
      erst_pkg::S_QOUT: begin
        res_handle = ram_rd_data;
        res_last   = (action_r == erst_pkg::ACT_RECEIVE) ||
                     (cur_cnt == erst_pkg::CNT_W'(1));
        if (out_free) begin
          emit_c         = 1'b1;
          head_nxt[sidx] = erst_pkg::ptr_next(head_r[sidx]);
          cnt_nxt[sidx]  = cur_cnt - erst_pkg::CNT_W'(1);
          if (res_last) begin
            state_nxt = erst_pkg::S_IDLE;
            if (action_r == erst_pkg::ACT_RELEASE) begin
              in_use_nxt[sidx] = 1'b0;
              head_nxt[sidx]   = '0;
              tail_nxt[sidx]   = '0;
            end
          end else begin
            state_nxt = erst_pkg::S_QRD;
          end
        end
      end
      default: begin
        state_nxt = erst_pkg::S_IDLE;
      end
    endcase

    out_valid_nxt = emit_c || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= erst_pkg::S_IDLE;
      in_use_r     <= '0;
      out_valid_r  <= 1'b0;
      free_found_r <= 1'b0;
      scan_idx_r   <= '0;
      for (int i = 0; i < erst_pkg::NUM_SLOTS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      in_use_r     <= in_use_nxt;
      out_valid_r  <= out_valid_nxt;
      free_found_r <= free_found_nxt;
      scan_idx_r   <= scan_idx_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    free_slot_r <= free_slot_nxt;
    if (in_valid && !in_stall) begin
      action_r <= erst_pkg::action_t'(in_action);
      sid_r    <= in_slot;
      key_hi_r <= in_remote_addr_hi;
      key_lo_r <= in_remote_addr_lo;
      handle_r <= in_packet_handle;
    end
    if (emit_c) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_handle_r <= res_handle;
      out_last_r   <= res_last;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_slot_out          = out_slot_r;
  assign out_packet_handle_out = out_handle_r;
  assign out_last              = out_last_r;

  for (genvar g = 0; g < erst_pkg::NUM_SLOTS; g++) begin : g_slot_chk
    a_free_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
      !in_use_r[g] |-> (cnt_r[g] == '0))
      else $error("free slot holds queued handles");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r[g] <= erst_pkg::CNT_W'(erst_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");
  end

  a_release_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_c && res_last && (state_r == erst_pkg::S_QOUT) &&
     (action_r == erst_pkg::ACT_RELEASE)) |=> !in_use_r[$past(sidx)])
    else $error("slot still in use after release");

  a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !emit_c)
    else $error("result emitted over a stalled transaction");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for echo_reply_slot_table_core: directed and random slot table
// transactions checked against a behavioral table predictor in a scoreboard.
// Depends on erst_pkg and the RTL top echo_reply_slot_table_core.
module testbench;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int RANDOM_ITEMS = 185;
  localparam int MAX_REPORTS  = 10;
  localparam int POOL_SIZE    = 12;

  typedef struct {
    erst_pkg::status_t                 status;
    logic [erst_pkg::SLOTO_W-1:0]      slot;
    logic [erst_pkg::HANDLE_W-1:0]     handle;
    logic                              last;
  } reply_t;

  class reply_table_scoreboard;
    bit                            in_use   [erst_pkg::NUM_SLOTS];
    logic [erst_pkg::ADDR_W-1:0]   addr_hi  [erst_pkg::NUM_SLOTS];
    logic [erst_pkg::ADDR_W-1:0]   addr_lo  [erst_pkg::NUM_SLOTS];
    logic [erst_pkg::HANDLE_W-1:0] handles  [erst_pkg::NUM_SLOTS][erst_pkg::QUEUE_DEPTH];
    int                            head     [erst_pkg::NUM_SLOTS];
    int                            tail     [erst_pkg::NUM_SLOTS];
    int                            count    [erst_pkg::NUM_SLOTS];
    reply_t                        expected_replies [$];
    int                            mismatches;

    function new();
      mismatches = 0;
      foreach (in_use[i]) begin
        in_use[i] = 1'b0;
        head[i]   = 0;
        tail[i]   = 0;
        count[i]  = 0;
      end
    endfunction

    function void push_reply(erst_pkg::status_t st, int s,
                             logic [erst_pkg::HANDLE_W-1:0] h, bit last);
      reply_t r;
      r.status = st;
      r.slot   = erst_pkg::SLOTO_W'(s);
      r.handle = h;
      r.last   = last;
      expected_replies.push_back(r);
    endfunction

    function void note_action(erst_pkg::action_t act, logic [erst_pkg::SID_W-1:0] sid,
                              logic [erst_pkg::ADDR_W-1:0] hi,
                              logic [erst_pkg::ADDR_W-1:0] lo,
                              logic [erst_pkg::HANDLE_W-1:0] h);
      int                            free_slot;
      int                            s;
      int                            i;
      logic [erst_pkg::HANDLE_W-1:0] discard;
      free_slot = -1;
      if (act == erst_pkg::ACT_REGISTER) begin
        for (i = 0; i < erst_pkg::NUM_SLOTS; i++) begin
          if (!in_use[i]) begin
            if (free_slot < 0) free_slot = i;
          end else if (addr_hi[i] == hi && addr_lo[i] == lo) begin
            push_reply(erst_pkg::ST_DUP, i, '0, 1'b1);
            return;
          end
        end
        if (free_slot < 0) begin
          push_reply(erst_pkg::ST_FULL_TABLE, 0, '0, 1'b1);
          return;
        end
        in_use[free_slot]  = 1'b1;
        addr_hi[free_slot] = hi;
        addr_lo[free_slot] = lo;
        head[free_slot]    = 0;
        tail[free_slot]    = 0;
        count[free_slot]   = 0;
        push_reply(erst_pkg::ST_OK, free_slot, '0, 1'b1);
        return;
      end
      discard = (act == erst_pkg::ACT_DELIVER) ? h : '0;
      if (sid >= erst_pkg::NUM_SLOTS) begin
        push_reply(erst_pkg::ST_BAD_SLOT, 0, discard, 1'b1);
        return;
      end
      s = int'(sid);
      if (!in_use[s]) begin
        push_reply(erst_pkg::ST_UNUSED, s, discard, 1'b1);
        return;
      end
      case (act)
        erst_pkg::ACT_DELIVER: begin
          if (count[s] >= erst_pkg::QUEUE_DEPTH) begin
            push_reply(erst_pkg::ST_FULL_QUEUE, s, h, 1'b1);
          end else begin
            handles[s][tail[s]] = h;
            tail[s] = (tail[s] + 1) % erst_pkg::QUEUE_DEPTH;
            count[s]++;
            push_reply(erst_pkg::ST_OK, s, '0, 1'b1);
          end
        end
        erst_pkg::ACT_RECEIVE: begin
          if (count[s] == 0) begin
            push_reply(erst_pkg::ST_EMPTY, s, '0, 1'b1);
          end else begin
            push_reply(erst_pkg::ST_OK, s, handles[s][head[s]], 1'b1);
            head[s] = (head[s] + 1) % erst_pkg::QUEUE_DEPTH;
            count[s]--;
          end
        end
        default: begin
          if (count[s] == 0) push_reply(erst_pkg::ST_OK, s, '0, 1'b1);
          while (count[s] > 0) begin
            count[s]--;
            push_reply(erst_pkg::ST_OK, s, handles[s][head[s]], count[s] == 0);
            head[s] = (head[s] + 1) % erst_pkg::QUEUE_DEPTH;
          end
          in_use[s] = 1'b0;
          head[s]   = 0;
          tail[s]   = 0;
        end
      endcase
    endfunction

    function void check_result(logic [erst_pkg::STATUS_W-1:0] st,
                               logic [erst_pkg::SLOTO_W-1:0] s,
                               logic [erst_pkg::HANDLE_W-1:0] h, logic last);
      reply_t e;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: status %0d slot %0d handle %h last %b",
                   st, s, h, last);
        return;
      end
      e = expected_replies.pop_front();
      if (e.status !== st || e.slot !== s || e.handle !== h || e.last !== last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch: expected status %0d slot %0d handle %h last %b,",
                   e.status, e.slot, e.handle, e.last);
          $display("          got status %0d slot %0d handle %h last %b",
                   st, s, h, last);
        end
      end
    endfunction

    function int outstanding();
      return expected_replies.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [erst_pkg::ACTION_W-1:0]   in_action = '0;
  logic [erst_pkg::SID_W-1:0]      in_slot = '0;
  logic [erst_pkg::ADDR_W-1:0]     in_remote_addr_hi = '0;
  logic [erst_pkg::ADDR_W-1:0]     in_remote_addr_lo = '0;
  logic [erst_pkg::HANDLE_W-1:0]   in_packet_handle = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [erst_pkg::STATUS_W-1:0]   out_status;
  logic [erst_pkg::SLOTO_W-1:0]    out_slot_out;
  logic [erst_pkg::HANDLE_W-1:0]   out_packet_handle_out;
  logic                            out_last;

  reply_table_scoreboard           sb;
  bit                              calm = 1'b0;
  int                              stall_left = 0;
  int unsigned                     cycle_count = 0;
  logic [erst_pkg::ADDR_W-1:0]     pool_hi [POOL_SIZE];
  logic [erst_pkg::ADDR_W-1:0]     pool_lo [POOL_SIZE];

  echo_reply_slot_table_core DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_action             (in_action),
    .in_slot               (in_slot),
    .in_remote_addr_hi     (in_remote_addr_hi),
    .in_remote_addr_lo     (in_remote_addr_lo),
    .in_packet_handle      (in_packet_handle),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_slot_out          (out_slot_out),
    .out_packet_handle_out (out_packet_handle_out),
    .out_last              (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 99) < 50) return 0;
    return idle_len();
  endfunction

  function automatic logic [erst_pkg::ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [erst_pkg::SID_W-1:0] pick_slot();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return erst_pkg::SID_W'($urandom_range(0, erst_pkg::NUM_SLOTS - 1));
    if (r < 95) return erst_pkg::SID_W'($urandom_range(erst_pkg::NUM_SLOTS, 65535));
    return erst_pkg::SID_W'($urandom);
  endfunction

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_slot_out, out_packet_handle_out, out_last);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      stall_left <= idle_len() - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_action(erst_pkg::action_t act, logic [erst_pkg::SID_W-1:0] sid,
                             logic [erst_pkg::ADDR_W-1:0] hi,
                             logic [erst_pkg::ADDR_W-1:0] lo,
                             logic [erst_pkg::HANDLE_W-1:0] h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= act;
    in_slot           <= sid;
    in_remote_addr_hi <= hi;
    in_remote_addr_lo <= lo;
    in_packet_handle  <= h;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_action(act, sid, hi, lo, h);
    if ($urandom_range(0, 29) == 0) calm <= !calm;
  endtask

  task automatic send_register(logic [erst_pkg::ADDR_W-1:0] hi,
                               logic [erst_pkg::ADDR_W-1:0] lo);
    send_action(erst_pkg::ACT_REGISTER, erst_pkg::SID_W'($urandom), hi, lo,
                erst_pkg::HANDLE_W'($urandom));
  endtask

  task automatic send_on_slot(erst_pkg::action_t act, logic [erst_pkg::SID_W-1:0] sid,
                              logic [erst_pkg::HANDLE_W-1:0] h);
    send_action(act, sid, rand64(), rand64(), h);
  endtask

  initial begin
    int                sent;
    int                r;
    int                s;
    int                n;
    int                k;
    int                p;
    erst_pkg::action_t act;

    sb = new();
    pool_hi[0] = '1;
    pool_lo[0] = '1;
    pool_hi[1] = '0;
    pool_lo[1] = '0;
    for (k = 2; k < POOL_SIZE; k++) begin
      pool_hi[k] = (k < 4) ? pool_hi[k - 2] : rand64();
      pool_lo[k] = rand64();
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: rejects on empty table, register corner cases, fill, queue basics
    send_on_slot(erst_pkg::ACT_RECEIVE, 16'd0, 16'h0000);
    send_on_slot(erst_pkg::ACT_DELIVER, 16'd3, 16'hFFFF);
    send_on_slot(erst_pkg::ACT_DELIVER, 16'hFFFF, 16'h1234);
    send_on_slot(erst_pkg::ACT_RECEIVE, erst_pkg::SID_W'(erst_pkg::NUM_SLOTS), 16'h0000);
    send_on_slot(erst_pkg::ACT_RELEASE, 16'h8000, 16'hFFFF);
    send_register('1, '1);
    send_register('1, '1);
    send_register('0, '0);
    send_register('1, '0);
    send_register('0, '1);
    send_on_slot(erst_pkg::ACT_RELEASE, 16'd1, 16'h0000);
    send_register('0, '0);
    for (k = 0; k < erst_pkg::NUM_SLOTS - 4; k++) send_register(rand64(), rand64());
    send_register(rand64(), rand64());
    send_register('1, '1);
    send_on_slot(erst_pkg::ACT_DELIVER, 16'd0, 16'h0000);
    send_on_slot(erst_pkg::ACT_DELIVER, 16'd0, 16'hFFFF);
    send_on_slot(erst_pkg::ACT_RECEIVE, 16'd0, 16'h0000);
    send_on_slot(erst_pkg::ACT_RELEASE, 16'd0, 16'h0000);
    send_on_slot(erst_pkg::ACT_RECEIVE, 16'd0, 16'h0000);
    send_register('1, '1);
    send_on_slot(erst_pkg::ACT_RECEIVE, 16'd0, 16'h0000);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // deliver QUEUE_DEPTH - 2 to QUEUE_DEPTH + 3 handles to one queue, usually a registered slot
        s = $urandom_range(0, erst_pkg::NUM_SLOTS - 1);
        for (k = 0; k < erst_pkg::NUM_SLOTS && !sb.in_use[s]; k++)
          s = (s + 1) % erst_pkg::NUM_SLOTS;
        n = $urandom_range(erst_pkg::QUEUE_DEPTH - 2, erst_pkg::QUEUE_DEPTH + 3);
        for (k = 0; k < n; k++)
          send_on_slot(erst_pkg::ACT_DELIVER, erst_pkg::SID_W'(s),
                       erst_pkg::HANDLE_W'($urandom));
        sent += n;
        if ($urandom_range(0, 1) == 1) begin
          send_on_slot(erst_pkg::ACT_RELEASE, erst_pkg::SID_W'(s),
                       erst_pkg::HANDLE_W'($urandom));
          sent++;
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 22) act = erst_pkg::ACT_REGISTER;
        else if (r < 55) act = erst_pkg::ACT_DELIVER;
        else if (r < 80) act = erst_pkg::ACT_RECEIVE;
        else act = erst_pkg::ACT_RELEASE;
        if (act == erst_pkg::ACT_REGISTER && $urandom_range(0, 3) != 0) begin
          p = $urandom_range(0, POOL_SIZE - 1);
          send_register(pool_hi[p], pool_lo[p]);
        end else begin
          send_action(act, pick_slot(), rand64(), rand64(), erst_pkg::HANDLE_W'($urandom));
        end
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
